>>> rtl/tca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tca_pkg
// Types and constants shared by the track to cluster association block.
// ----------------------------------------------------------------------------
package tca_pkg;

   // Item kinds on the request channel
   typedef enum logic [1:0] {
      MODE_TRACK   = 2'd0,
      MODE_CLUSTER = 2'd1,
      MODE_PIXEL   = 2'd2,
      MODE_END     = 2'd3
   } mode_type;

   // Verdict codes
   localparam logic [1:0] VERDICT_ASSOC   = 2'd0;
   localparam logic [1:0] VERDICT_SPATIAL = 2'd1;
   localparam logic [1:0] VERDICT_TIME    = 2'd2;

   // Result kinds
   localparam logic RESULT_VERDICT = 1'b0;
   localparam logic RESULT_SUMMARY = 1'b1;

   // Register indexes on the configuration port
   localparam logic [2:0] REG_CUT_X      = 3'd0;
   localparam logic [2:0] REG_CUT_Y      = 3'd1;
   localparam logic [2:0] REG_DT_LIMIT   = 3'd2;
   localparam logic [2:0] REG_USE_CENTRE = 3'd3;
   localparam logic [2:0] REG_ELLIPTIC   = 3'd4;

   localparam int STAMP_BITS    = 48;
   localparam int DT_LIMIT_BITS = 40;
   localparam int CSR_DATA_BITS = 64;
   localparam int CSR_ADDR_BITS = 6;
   localparam int OPND_BITS     = 32;
   localparam int PROD_BITS     = 2 * OPND_BITS;
   localparam int ACC_BITS      = 129;

   // Last sequencer step of the arithmetic pass
   localparam logic [4:0] STEP_LAST = 5'd18;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_CALC = 2'd1,
      ST_DONE = 2'd2
   } state_type;

   // Product alignment in the accumulator
   typedef enum logic [1:0] {
      SHIFT_0  = 2'd0,
      SHIFT_32 = 2'd1,
      SHIFT_64 = 2'd2
   } shift_type;

   // One operation issued to the multiply-accumulate unit
   typedef struct packed {
      logic      issue;
      logic      clear;
      logic      neg;
      shift_type shift;
   } mac_op_type;

endpackage

>>> rtl/tca_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tca_csr
// Configuration registers behind an APB-style port.
// ----------------------------------------------------------------------------
module tca_csr #(
   parameter int COORD_BITS = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [tca_pkg::CSR_ADDR_BITS-1:0]    paddr,
   input  logic [tca_pkg::CSR_DATA_BITS-1:0]    pwdata,
   output logic [tca_pkg::CSR_DATA_BITS-1:0]    prdata,
   output logic                                 pready,
   output logic [COORD_BITS-2:0]                cut_x,
   output logic [COORD_BITS-2:0]                cut_y,
   output logic [tca_pkg::DT_LIMIT_BITS-1:0]    dt_limit,
   output logic                                 use_centre,
   output logic                                 elliptic
);

   logic [COORD_BITS-2:0]             cut_x_ff, cut_y_ff;
   logic [tca_pkg::DT_LIMIT_BITS-1:0] dt_limit_ff;
   logic                              use_centre_ff, elliptic_ff;
   logic [2:0]                        index;
   logic                              wr_en;

   assign index  = paddr[5:3];
   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;

   // Write registers on the access beat
   always_ff @(posedge clock) begin
      if (reset) begin
         cut_x_ff      <= (COORD_BITS-1)'(1000);
         cut_y_ff      <= (COORD_BITS-1)'(1000);
         dt_limit_ff   <= tca_pkg::DT_LIMIT_BITS'(100000);
         use_centre_ff <= 1'b0;
         elliptic_ff   <= 1'b1;
      end else if (wr_en) begin
         case (index)
            tca_pkg::REG_CUT_X:      cut_x_ff <= pwdata[COORD_BITS-2:0];
            tca_pkg::REG_CUT_Y:      cut_y_ff <= pwdata[COORD_BITS-2:0];
            tca_pkg::REG_DT_LIMIT:   dt_limit_ff <= pwdata[tca_pkg::DT_LIMIT_BITS-1:0];
            tca_pkg::REG_USE_CENTRE: use_centre_ff <= pwdata[0];
            tca_pkg::REG_ELLIPTIC:   elliptic_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   // Read back
   always_comb begin
      prdata = '0;
      case (index)
         tca_pkg::REG_CUT_X:      prdata = tca_pkg::CSR_DATA_BITS'(cut_x_ff);
         tca_pkg::REG_CUT_Y:      prdata = tca_pkg::CSR_DATA_BITS'(cut_y_ff);
         tca_pkg::REG_DT_LIMIT:   prdata = tca_pkg::CSR_DATA_BITS'(dt_limit_ff);
         tca_pkg::REG_USE_CENTRE: prdata = tca_pkg::CSR_DATA_BITS'(use_centre_ff);
         tca_pkg::REG_ELLIPTIC:   prdata = tca_pkg::CSR_DATA_BITS'(elliptic_ff);
         default:                 prdata = '0;
      endcase
   end

   assign cut_x      = cut_x_ff;
   assign cut_y      = cut_y_ff;
   assign dt_limit   = dt_limit_ff;
   assign use_centre = use_centre_ff;
   assign elliptic   = elliptic_ff;

endmodule

>>> rtl/tca_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tca_mac
// Shared 32x32 multiplier with a registered product and a wide signed
// accumulator that adds or subtracts the aligned product.
// ----------------------------------------------------------------------------
module tca_mac (
   input  logic                                clock,
   input  logic                                reset,
   input  tca_pkg::mac_op_type                 op,
   input  logic [tca_pkg::OPND_BITS-1:0]       opnd_a,
   input  logic [tca_pkg::OPND_BITS-1:0]       opnd_b,
   output logic [tca_pkg::ACC_BITS-1:0]        acc
);

   tca_pkg::mac_op_type                 op_ff;
   logic [tca_pkg::PROD_BITS-1:0]       prod_ff;
   logic [tca_pkg::ACC_BITS-1:0]        acc_ff, acc_in, term, base;

   // Multiply stage
   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff <= '0;
      end else begin
         op_ff <= op;
      end
      prod_ff <= opnd_a * opnd_b;
   end

   // Align, negate and accumulate
   always_comb begin
      term = tca_pkg::ACC_BITS'(prod_ff);
      case (op_ff.shift)
         tca_pkg::SHIFT_0:  term = tca_pkg::ACC_BITS'(prod_ff);
         tca_pkg::SHIFT_32: term = tca_pkg::ACC_BITS'(prod_ff) << 32;
         tca_pkg::SHIFT_64: term = tca_pkg::ACC_BITS'(prod_ff) << 64;
         default:           term = tca_pkg::ACC_BITS'(prod_ff);
      endcase
      if (op_ff.neg) begin
         term = -term;
      end
      base   = op_ff.clear ? '0 : acc_ff;
      acc_in = op_ff.issue ? base + term : acc_ff;
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

>>> rtl/track_cluster_association.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// track_cluster_association
// Associates clusters to a track with an elliptic or rectangular spatial
// window and a time window, and tracks the closest associated cluster.
// ----------------------------------------------------------------------------
// Track headers, cluster headers, pixels that are not the last of a cluster
// and end-of-track marks take one cycle each while the block is idle. The
// verdict for a last pixel is worked out on one shared 32x32 multiplier that
// runs 17 products in turn (three cross products, three 64-bit squares built
// from partial products, and the squared distance), plus pipeline latency;
// the block takes no new item until the verdict beat is loaded into the
// output register. An end-of-track mark also waits for it to be free.
// ----------------------------------------------------------------------------
module track_cluster_association #(
   parameter int COORD_BITS      = 24,
   parameter int CLUSTER_ID_BITS = 10
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_mode,
   input  logic signed [COORD_BITS-1:0]         req_pos_x,
   input  logic signed [COORD_BITS-1:0]         req_pos_y,
   input  logic [tca_pkg::STAMP_BITS-1:0]       req_stamp,
   input  logic [CLUSTER_ID_BITS-1:0]           req_cluster_tag,
   input  logic                                 req_last_pixel,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_result_kind,
   output logic [CLUSTER_ID_BITS-1:0]           rsp_verdict_cluster,
   output logic [1:0]                           rsp_verdict,
   output logic                                 rsp_now_closest,
   output logic [CLUSTER_ID_BITS:0]             rsp_assoc_count,
   output logic [CLUSTER_ID_BITS-1:0]           rsp_closest_cluster,
   output logic                                 rsp_has_closest,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [tca_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [tca_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [tca_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                 csr_pready
);

   localparam int C    = COORD_BITS;
   localparam int ID   = CLUSTER_ID_BITS;
   localparam int DSQ  = 2 * COORD_BITS + 2;
   localparam logic [ID:0] TALLY_MAX = (ID+1)'(1) << ID;

   // Configuration
   logic [C-2:0]                      cut_x, cut_y;
   logic [tca_pkg::DT_LIMIT_BITS-1:0] dt_limit;
   logic                              use_centre, elliptic;

   tca_csr #(.COORD_BITS(C)) u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (csr_psel),
      .penable    (csr_penable),
      .pwrite     (csr_pwrite),
      .paddr      (csr_paddr),
      .pwdata     (csr_pwdata),
      .prdata     (csr_prdata),
      .pready     (csr_pready),
      .cut_x      (cut_x),
      .cut_y      (cut_y),
      .dt_limit   (dt_limit),
      .use_centre (use_centre),
      .elliptic   (elliptic)
   );

   // Track and cluster state
   logic [C-1:0]                   track_x_ff, track_y_ff;
   logic [tca_pkg::STAMP_BITS-1:0] track_time_ff, cluster_time_ff;
   logic [C-1:0]                   centre_dx_ff, centre_dy_ff;
   logic [ID-1:0]                  cluster_id_ff, best_cluster_ff;
   logic [C:0]                     near_dx_ff, near_dy_ff;
   logic [DSQ-1:0]                 best_dsq_ff;
   logic [ID:0]                    tally_ff;
   logic [C-1:0]                   dx_ff, dy_ff;
   logic [tca_pkg::PROD_BITS-1:0]  t1_ff, t2_ff, t3_ff;
   logic                           ell_rej_ff;
   logic [4:0]                     step_ff;
   tca_pkg::state_type             state_ff, state_in;

   // Result staging and output register
   logic                           res_valid_ff;
   logic [ID-1:0]                  res_cluster_ff;
   logic [1:0]                     res_verdict_ff;
   logic                           res_closest_ff;
   logic                           out_valid_ff;
   logic                           out_kind_ff;
   logic [ID-1:0]                  out_cluster_ff;
   logic [1:0]                     out_verdict_ff;
   logic                           out_closest_ff;
   logic [ID:0]                    out_count_ff;
   logic [ID-1:0]                  out_best_ff;
   logic                           out_has_ff;

   tca_pkg::mode_type              mode;
   logic                           accept, slot_free;
   logic [C:0]                     diff_x, diff_y;
   logic [C-1:0]                   abs_x, abs_y;
   logic [C:0]                     near_x_new, near_y_new;

   tca_pkg::mac_op_type            op;
   logic [tca_pkg::OPND_BITS-1:0]  opnd_a, opnd_b;
   logic [tca_pkg::ACC_BITS-1:0]   acc;

   logic [tca_pkg::OPND_BITS-1:0]  a32, b32, dx32, dy32;
   logic                           rect_rej, sp_rej, time_rej;
   logic [tca_pkg::STAMP_BITS-1:0] dt;
   logic [DSQ-1:0]                 dsq;

   assign mode      = tca_pkg::mode_type'(req_mode);
   assign slot_free = !out_valid_ff || rsp_ready;
   assign req_ready = (state_ff == tca_pkg::ST_IDLE) &&
                      ((mode != tca_pkg::MODE_END) || slot_free);
   assign accept    = req_valid && req_ready;

   // Absolute distance from the track intercept
   always_comb begin
      diff_x = {track_x_ff[C-1], track_x_ff} - {req_pos_x[C-1], req_pos_x};
      diff_y = {track_y_ff[C-1], track_y_ff} - {req_pos_y[C-1], req_pos_y};
      abs_x  = diff_x[C] ? C'(-diff_x) : diff_x[C-1:0];
      abs_y  = diff_y[C] ? C'(-diff_y) : diff_y[C-1:0];
      near_x_new = ((C+1)'(abs_x) < near_dx_ff) ? (C+1)'(abs_x) : near_dx_ff;
      near_y_new = ((C+1)'(abs_y) < near_dy_ff) ? (C+1)'(abs_y) : near_dy_ff;
   end

   // Operand selection for the shared unit
   assign a32  = tca_pkg::OPND_BITS'(cut_x);
   assign b32  = tca_pkg::OPND_BITS'(cut_y);
   assign dx32 = tca_pkg::OPND_BITS'(dx_ff);
   assign dy32 = tca_pkg::OPND_BITS'(dy_ff);

   always_comb begin
      op     = '0;
      opnd_a = '0;
      opnd_b = '0;
      if (state_ff == tca_pkg::ST_CALC) begin
         op.issue = 1'b1;
         op.shift = tca_pkg::SHIFT_0;
         case (step_ff)
            5'd0: begin opnd_a = dx32; opnd_b = b32; op.clear = 1'b1; end
            5'd1: begin opnd_a = dy32; opnd_b = a32; op.clear = 1'b1; end
            5'd2: begin opnd_a = a32;  opnd_b = b32; op.clear = 1'b1; end
            5'd3: begin
               opnd_a = t1_ff[31:0]; opnd_b = t1_ff[31:0]; op.clear = 1'b1;
            end
            5'd4, 5'd5: begin
               opnd_a = t1_ff[31:0]; opnd_b = t1_ff[63:32]; op.shift = tca_pkg::SHIFT_32;
            end
            5'd6: begin
               opnd_a = t1_ff[63:32]; opnd_b = t1_ff[63:32]; op.shift = tca_pkg::SHIFT_64;
            end
            5'd7: begin opnd_a = t2_ff[31:0]; opnd_b = t2_ff[31:0]; end
            5'd8, 5'd9: begin
               opnd_a = t2_ff[31:0]; opnd_b = t2_ff[63:32]; op.shift = tca_pkg::SHIFT_32;
            end
            5'd10: begin
               opnd_a = t2_ff[63:32]; opnd_b = t2_ff[63:32]; op.shift = tca_pkg::SHIFT_64;
            end
            5'd11: begin
               opnd_a = t3_ff[31:0]; opnd_b = t3_ff[31:0]; op.neg = 1'b1;
            end
            5'd12, 5'd13: begin
               opnd_a = t3_ff[31:0]; opnd_b = t3_ff[63:32];
               op.shift = tca_pkg::SHIFT_32; op.neg = 1'b1;
            end
            5'd14: begin
               opnd_a = t3_ff[63:32]; opnd_b = t3_ff[63:32];
               op.shift = tca_pkg::SHIFT_64; op.neg = 1'b1;
            end
            5'd15: begin opnd_a = dx32; opnd_b = dx32; op.clear = 1'b1; end
            5'd16: begin opnd_a = dy32; opnd_b = dy32; end
            default: op.issue = 1'b0;
         endcase
      end
   end

   tca_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .op     (op),
      .opnd_a (opnd_a),
      .opnd_b (opnd_b),
      .acc    (acc)
   );

   // Window tests on the final step
   always_comb begin
      rect_rej = ((C)'(cut_x) < dx_ff) || ((C)'(cut_y) < dy_ff);
      sp_rej   = (elliptic && (cut_x != '0) && (cut_y != '0)) ? ell_rej_ff : rect_rej;
      dt       = (cluster_time_ff > track_time_ff) ? cluster_time_ff - track_time_ff
                                                  : track_time_ff - cluster_time_ff;
      time_rej = dt > tca_pkg::STAMP_BITS'(dt_limit);
      dsq      = acc[DSQ-1:0];
   end

   // Sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tca_pkg::ST_IDLE:
            if (accept && mode == tca_pkg::MODE_PIXEL && req_last_pixel) begin
               state_in = tca_pkg::ST_CALC;
            end
         tca_pkg::ST_CALC:
            if (step_ff == tca_pkg::STEP_LAST) begin
               state_in = tca_pkg::ST_DONE;
            end
         tca_pkg::ST_DONE:
            if (slot_free) begin
               state_in = tca_pkg::ST_IDLE;
            end
         default: state_in = tca_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tca_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Step counter and captures from the accumulator
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else if (state_ff == tca_pkg::ST_CALC) begin
         step_ff <= step_ff + 5'd1;
      end else begin
         step_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == tca_pkg::ST_CALC) begin
         case (step_ff)
            5'd2:  t1_ff <= acc[tca_pkg::PROD_BITS-1:0];
            5'd3:  t2_ff <= acc[tca_pkg::PROD_BITS-1:0];
            5'd4:  t3_ff <= acc[tca_pkg::PROD_BITS-1:0];
            5'd16: ell_rej_ff <= !acc[tca_pkg::ACC_BITS-1] && (acc != '0);
            default: ;
         endcase
      end
   end

   // Track state, cluster state and verdict bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         track_x_ff      <= '0;
         track_y_ff      <= '0;
         track_time_ff   <= '0;
         centre_dx_ff    <= '0;
         centre_dy_ff    <= '0;
         cluster_time_ff <= '0;
         cluster_id_ff   <= '0;
         near_dx_ff      <= '1;
         near_dy_ff      <= '1;
         best_dsq_ff     <= '1;
         best_cluster_ff <= '0;
         tally_ff        <= '0;
         res_valid_ff    <= 1'b0;
      end else begin
         if (accept) begin
            case (mode)
               tca_pkg::MODE_TRACK: begin
                  track_x_ff      <= req_pos_x;
                  track_y_ff      <= req_pos_y;
                  track_time_ff   <= req_stamp;
                  tally_ff        <= '0;
                  best_cluster_ff <= '0;
                  best_dsq_ff     <= '1;
                  near_dx_ff      <= '1;
                  near_dy_ff      <= '1;
               end
               tca_pkg::MODE_CLUSTER: begin
                  centre_dx_ff    <= abs_x;
                  centre_dy_ff    <= abs_y;
                  cluster_time_ff <= req_stamp;
                  cluster_id_ff   <= req_cluster_tag;
                  near_dx_ff      <= '1;
                  near_dy_ff      <= '1;
               end
               tca_pkg::MODE_PIXEL: begin
                  if (req_last_pixel) begin
                     near_dx_ff <= '1;
                     near_dy_ff <= '1;
                  end else begin
                     near_dx_ff <= near_x_new;
                     near_dy_ff <= near_y_new;
                  end
               end
               default: ;
            endcase
         end
         // Settle the verdict on the last step
         if (state_ff == tca_pkg::ST_CALC && step_ff == tca_pkg::STEP_LAST) begin
            res_valid_ff   <= 1'b1;
            res_cluster_ff <= cluster_id_ff;
            res_closest_ff <= 1'b0;
            if (sp_rej) begin
               res_verdict_ff <= tca_pkg::VERDICT_SPATIAL;
            end else if (time_rej) begin
               res_verdict_ff <= tca_pkg::VERDICT_TIME;
            end else begin
               res_verdict_ff <= tca_pkg::VERDICT_ASSOC;
               if (tally_ff != TALLY_MAX) begin
                  tally_ff <= tally_ff + (ID+1)'(1);
               end
               if (best_dsq_ff > dsq) begin
                  best_dsq_ff     <= dsq;
                  best_cluster_ff <= cluster_id_ff;
                  res_closest_ff  <= 1'b1;
               end
            end
         end else if (state_ff == tca_pkg::ST_DONE && slot_free) begin
            res_valid_ff <= 1'b0;
         end
      end
   end

   // Latch the distances used by the window test
   always_ff @(posedge clock) begin
      if (accept && mode == tca_pkg::MODE_PIXEL && req_last_pixel) begin
         dx_ff <= use_centre ? centre_dx_ff : near_x_new[C-1:0];
         dy_ff <= use_centre ? centre_dy_ff : near_y_new[C-1:0];
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (accept && mode == tca_pkg::MODE_END) begin
         out_valid_ff <= 1'b1;
      end else if (state_ff == tca_pkg::ST_DONE && res_valid_ff && slot_free) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && mode == tca_pkg::MODE_END) begin
         out_kind_ff    <= tca_pkg::RESULT_SUMMARY;
         out_cluster_ff <= '0;
         out_verdict_ff <= tca_pkg::VERDICT_ASSOC;
         out_closest_ff <= 1'b0;
         out_count_ff   <= tally_ff;
         out_best_ff    <= best_cluster_ff;
         out_has_ff     <= (tally_ff != '0);
      end else if (state_ff == tca_pkg::ST_DONE && res_valid_ff && slot_free) begin
         out_kind_ff    <= tca_pkg::RESULT_VERDICT;
         out_cluster_ff <= res_cluster_ff;
         out_verdict_ff <= res_verdict_ff;
         out_closest_ff <= res_closest_ff;
         out_count_ff   <= '0;
         out_best_ff    <= '0;
         out_has_ff     <= 1'b0;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_result_kind     = out_kind_ff;
   assign rsp_verdict_cluster = out_cluster_ff;
   assign rsp_verdict         = out_verdict_ff;
   assign rsp_now_closest     = out_closest_ff;
   assign rsp_assoc_count     = out_count_ff;
   assign rsp_closest_cluster = out_best_ff;
   assign rsp_has_closest     = out_has_ff;

endmodule
